// ----- hw/rtl/mm3_pkg.sv -----
// Shared constants, types and state encodings for the 3x3 integer matrix multiplier.
`default_nettype none

package mm3_pkg;

    localparam int DIM_DEFAULT = 3;
    localparam int ELEM_W      = 16;
    localparam int MUL_W       = 2 * ELEM_W;
    localparam int PROD_W      = 33;

    typedef struct packed {
        logic vld;
        logic bank;
    } tok_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ISSUE,
        BK_WAIT
    } back_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mm3_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module mm3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/mm3_queue.sv -----
// Two-entry queue of run tokens between the load front end and the compute back end.
`default_nettype none

module mm3_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire mm3_pkg::tok_t push,
    input  wire logic        pop,
    output mm3_pkg::tok_t    head,
    output logic             full
);

    import mm3_pkg::*;

    logic       ent_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;

    assign do_push = push.vld && (cnt_reg != 2'd2);
    assign do_pop  = pop && (cnt_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= push.bank;
        end
    end

    assign head.vld  = (cnt_reg != 2'd0);
    assign head.bank = ent_reg[rd_ptr_reg];
    assign full      = (cnt_reg == 2'd2);

endmodule

`default_nettype wire

// ----- hw/rtl/mm3_front.sv -----
// Load front end: takes matrix elements, writes them into the current bank and closes each run.
`default_nettype none

module mm3_front #(
    parameter int DIM = mm3_pkg::DIM_DEFAULT,
    parameter int IDX_W = $clog2(DIM * DIM)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        element_valid,
    output logic                             element_stall,
    input  wire logic [mm3_pkg::ELEM_W-1:0]  element,
    input  wire logic                        q_full,
    output mm3_pkg::tok_t                    push,
    output logic                             a_we,
    output logic                             b_we,
    output logic [IDX_W:0]                   wr_addr,
    output logic [mm3_pkg::ELEM_W-1:0]       wr_data
);

    import mm3_pkg::*;

    localparam int CELLS = DIM * DIM;
    localparam int CNT_W = $clog2(2 * CELLS);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             bank_reg;
    logic             bank_next;
    logic             accept;
    logic             in_left;
    logic             final_load;
    logic [CNT_W-1:0] b_off;

    // A run may only start filling a bank once the back end has released it.
    assign element_stall = q_full;
    assign accept        = element_valid && !q_full;
    assign in_left       = (cnt_reg < CNT_W'(CELLS));
    assign final_load    = (cnt_reg == CNT_W'(2 * CELLS - 1));
    assign b_off         = cnt_reg - CNT_W'(CELLS);

    always_comb
    begin
        cnt_next  = cnt_reg;
        bank_next = bank_reg;
        if (accept)
        begin
            if (final_load)
            begin
                cnt_next  = '0;
                bank_next = ~bank_reg;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            bank_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            bank_reg <= bank_next;
        end
    end

    assign a_we      = accept && in_left;
    assign b_we      = accept && !in_left;
    assign wr_addr   = in_left ? {bank_reg, cnt_reg[IDX_W-1:0]} : {bank_reg, b_off[IDX_W-1:0]};
    assign wr_data   = element;
    assign push.vld  = accept && final_load;
    assign push.bank = bank_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/mm3_back.sv -----
// Compute back end: multiply-accumulate over the stored matrices and output register.
`default_nettype none

module mm3_back #(
    parameter int DIM = mm3_pkg::DIM_DEFAULT,
    parameter int IDX_W = $clog2(DIM * DIM)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire mm3_pkg::tok_t                q_head,
    output logic                              q_pop,
    output logic [IDX_W:0]                    a_rd_addr,
    output logic [IDX_W:0]                    b_rd_addr,
    input  wire logic [mm3_pkg::ELEM_W-1:0]   a_rd_data,
    input  wire logic [mm3_pkg::ELEM_W-1:0]   b_rd_data,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output logic [mm3_pkg::PROD_W-1:0]        product,
    output logic                              last
);

    import mm3_pkg::*;

    localparam int RC_W = $clog2(DIM);

    back_state_t state_reg;
    back_state_t state_next;

    logic [RC_W-1:0] row_reg;
    logic [RC_W-1:0] row_next;
    logic [RC_W-1:0] col_reg;
    logic [RC_W-1:0] col_next;
    logic [RC_W-1:0] k_reg;
    logic [RC_W-1:0] k_next;

    logic issue;
    logic k_end;
    logic elem_end;
    logic load_out;

    logic rd_vld_reg;
    logic rd_first_reg;
    logic rd_lastk_reg;
    logic mul_vld_reg;
    logic mul_first_reg;
    logic mul_lastk_reg;
    logic sum_rdy_reg;
    logic sum_rdy_next;
    logic out_vld_reg;
    logic out_vld_next;

    logic signed [MUL_W-1:0]  mul_next;
    logic signed [MUL_W-1:0]  mul_reg;
    logic        [PROD_W-1:0] mul_ext;
    logic        [PROD_W-1:0] acc_reg;
    logic        [PROD_W-1:0] product_reg;
    logic                     last_reg;

    assign k_end    = (k_reg == RC_W'(DIM - 1));
    assign elem_end = (row_reg == RC_W'(DIM - 1)) && (col_reg == RC_W'(DIM - 1));
    assign issue    = (state_reg == BK_ISSUE);
    assign load_out = (state_reg == BK_WAIT) && sum_rdy_reg && (!out_vld_reg || !result_stall);

    assign a_rd_addr = {q_head.bank,
                        IDX_W'(row_reg) * IDX_W'(DIM) + IDX_W'(k_reg)};
    assign b_rd_addr = {q_head.bank,
                        IDX_W'(k_reg) * IDX_W'(DIM) + IDX_W'(col_reg)};

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        k_next     = k_reg;
        q_pop      = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_head.vld)
                begin
                    row_next   = '0;
                    col_next   = '0;
                    k_next     = '0;
                    state_next = BK_ISSUE;
                end
            end
            BK_ISSUE:
            begin
                if (k_end)
                begin
                    k_next     = '0;
                    state_next = BK_WAIT;
                end
                else
                begin
                    k_next = k_reg + RC_W'(1);
                end
            end
            BK_WAIT:
            begin
                if (load_out)
                begin
                    if (elem_end)
                    begin
                        q_pop      = 1'b1;
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        state_next = BK_ISSUE;
                        if (col_reg == RC_W'(DIM - 1))
                        begin
                            col_next = '0;
                            row_next = row_reg + RC_W'(1);
                        end
                        else
                        begin
                            col_next = col_reg + RC_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sum_rdy_next = sum_rdy_reg;
        if (mul_vld_reg && mul_lastk_reg)
        begin
            sum_rdy_next = 1'b1;
        end
        else if (load_out)
        begin
            sum_rdy_next = 1'b0;
        end
        out_vld_next = load_out || (out_vld_reg && result_stall);
    end

    assign mul_next = $signed(a_rd_data) * $signed(b_rd_data);
    assign mul_ext  = {{(PROD_W - MUL_W){mul_reg[MUL_W-1]}}, mul_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            k_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            rd_first_reg  <= 1'b0;
            rd_lastk_reg  <= 1'b0;
            mul_vld_reg   <= 1'b0;
            mul_first_reg <= 1'b0;
            mul_lastk_reg <= 1'b0;
            sum_rdy_reg   <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            k_reg         <= k_next;
            rd_vld_reg    <= issue;
            rd_first_reg  <= issue && (k_reg == '0);
            rd_lastk_reg  <= issue && k_end;
            mul_vld_reg   <= rd_vld_reg;
            mul_first_reg <= rd_first_reg;
            mul_lastk_reg <= rd_lastk_reg;
            sum_rdy_reg   <= sum_rdy_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_next;
        if (mul_vld_reg)
        begin
            acc_reg <= mul_first_reg ? mul_ext : acc_reg + mul_ext;
        end
        if (load_out)
        begin
            product_reg <= acc_reg;
            last_reg    <= elem_end;
        end
    end

    assign result_valid = out_vld_reg;
    assign product      = product_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/matrix_multiply_3x3.sv -----
// Top level of the DIM by DIM signed integer matrix multiplier.
`default_nettype none

// The block takes signed 16-bit elements one per transfer: first the DIM*DIM
// elements of the left matrix, then the DIM*DIM elements of the right matrix,
// each in row-major order. After the last right-matrix element it delivers the
// DIM*DIM elements of the product in row-major order, 33 bits signed, with
// last high on the bottom-right element. Loading runs at one element per cycle
// into one of two banks of the operand memories, so the next pair of matrices
// can be loaded while the previous product is still being computed; the input
// stalls only when both banks hold runs that the compute side has not finished.
// The compute side has a single 16 by 16 multiplier and one read port on each
// operand memory, so it forms the product elements one after another: the DIM
// terms of each are read, multiplied and summed, and the sum is then handed to
// the output register. A stalled output holds the compute side once the next
// element is ready. The operand memories need no clearing after reset.

module matrix_multiply_3x3 #(
    parameter int DIM = mm3_pkg::DIM_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        element_valid,
    output logic                             element_stall,
    input  wire logic [mm3_pkg::ELEM_W-1:0]  element,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output logic [mm3_pkg::PROD_W-1:0]       product,
    output logic                             last
);

    import mm3_pkg::*;

    // Each memory holds two banks of 2^IDX_W entries (DIM*DIM used), addressed as {bank, index}.
    localparam int IDX_W = $clog2(DIM * DIM);
    localparam int DEPTH = 2 << IDX_W;

    tok_t             push;
    tok_t             q_head;
    logic             q_full;
    logic             q_pop;
    logic             a_we;
    logic             b_we;
    logic [IDX_W:0]   wr_addr;
    logic [ELEM_W-1:0] wr_data;
    logic [IDX_W:0]   a_rd_addr;
    logic [IDX_W:0]   b_rd_addr;
    logic [ELEM_W-1:0] a_rd_data;
    logic [ELEM_W-1:0] b_rd_data;

    // The front end writes elements and closes a run with a token naming its bank.
    mm3_front #(
        .DIM   (DIM),
        .IDX_W (IDX_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .element_valid (element_valid),
        .element_stall (element_stall),
        .element       (element),
        .q_full        (q_full),
        .push          (push),
        .a_we          (a_we),
        .b_we          (b_we),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    // The token stays at the head of the queue until its bank has been read in full.
    mm3_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (q_pop),
        .head  (q_head),
        .full  (q_full)
    );

    mm3_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_left_ram (
        .clk     (clk),
        .we      (a_we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    mm3_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_right_ram (
        .clk     (clk),
        .we      (b_we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    // The back end walks rows, columns and inner index, one product term a cycle in BK_ISSUE.
    mm3_back #(
        .DIM   (DIM),
        .IDX_W (IDX_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .a_rd_addr    (a_rd_addr),
        .b_rd_addr    (b_rd_addr),
        .a_rd_data    (a_rd_data),
        .b_rd_data    (b_rd_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .product      (product),
        .last         (last)
    );

endmodule

`default_nettype wire

// ----- tb/matrix_multiply_3x3_tb.sv -----
// Self-checking testbench for the 3x3 signed integer matrix multiplier.
`timescale 1ns / 1ps

module matrix_multiply_3x3_tb;

    import mm3_pkg::*;

    // Block size and derived counts. The product field is wide enough that the
    // sums never wrap at the default size.
    localparam int DIM           = DIM_DEFAULT;
    localparam int CELLS         = DIM * DIM;
    localparam int RUN_ITEMS     = 2 * CELLS;
    localparam int DIRECTED_N    = 25;
    localparam int RANDOM_N      = 299;
    localparam int SETTLE_AT     = 162;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AFTER    = 20;
    localparam int DRAIN_CYCLES  = 64;
    localparam int WATCHDOG_LIM  = 2000;
    localparam int REPORT_LIMIT  = 10;

    // Products that can be read straight off the first directed run, where the
    // left matrix is all most-negative values and every row of the right matrix
    // is most-negative, most-positive, zero.
    localparam logic [PROD_W-1:0] PROD_TOP = 33'sd3221225472;
    localparam logic [PROD_W-1:0] PROD_LOW = -33'sd3221127168;
    localparam logic [PROD_W-1:0] PROD_NIL = '0;

    typedef struct {
        logic [ELEM_W-1:0] elem;
        bit                typed;
        logic [PROD_W-1:0] want;
    } stim_row_t;

    typedef struct {
        logic [PROD_W-1:0] product;
        logic              last;
    } product_cell_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                element_valid;
    logic                element_stall;
    logic [ELEM_W-1:0]   element;
    logic                result_valid;
    logic                result_stall;
    logic [PROD_W-1:0]   product;
    logic                last;

    // Our own copy of the operand matrices and the load position.
    logic signed [ELEM_W-1:0] left_cells  [CELLS];
    logic signed [ELEM_W-1:0] right_cells [CELLS];
    int unsigned              loaded;

    // Products still owed by the block, oldest first, and the hand-typed values
    // that replace the computed ones for the first run.
    product_cell_t     expected_products [$];
    logic [PROD_W-1:0] typed_products [$];
    product_cell_t     front_cell;

    stim_row_t directed_rows [DIRECTED_N];

    int failures;
    int items_sent;
    int results_taken;
    int input_held_cycles;
    int quiet_cycles;
    bit long_hold_done;

    matrix_multiply_3x3 #(
        .DIM (DIM)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .element_valid (element_valid),
        .element_stall (element_stall),
        .element       (element),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .product       (product),
        .last          (last)
    );

    // A 2 ns clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mismatches beyond the first few are only counted, to keep the log short.
    function automatic void log_failure(input string what);
        failures++;
        if (failures <= REPORT_LIMIT)
        begin
            $display("%s", what);
        end
    endfunction

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Element values lean towards the extremes and small magnitudes so that the
    // sums reach both ends of the product range as well as the middle.
    function automatic logic [ELEM_W-1:0] rand_element();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'($urandom_range(0, 7));
            default: return 16'($urandom());
        endcase
    endfunction

    // Stores one accepted element and, on the last element of the right matrix,
    // works out all nine product elements in row-major order.
    task automatic load_and_multiply(input logic signed [ELEM_W-1:0] e);
        longint        acc;
        product_cell_t owed;
        if (loaded < CELLS)
            left_cells[loaded] = e;
        else
            right_cells[loaded - CELLS] = e;
        loaded++;
        if (loaded == RUN_ITEMS)
        begin
            loaded = 0;
            for (int r = 0; r < DIM; r++)
            begin
                for (int c = 0; c < DIM; c++)
                begin
                    acc = 0;
                    for (int k = 0; k < DIM; k++)
                    begin
                        acc += longint'(left_cells[r * DIM + k]) *
                               longint'(right_cells[k * DIM + c]);
                    end
                    owed.product = acc[PROD_W-1:0];
                    owed.last    = (r * DIM + c == CELLS - 1);
                    if (typed_products.size() != 0)
                        owed.product = typed_products.pop_front();
                    expected_products.push_back(owed);
                end
            end
        end
    endtask

    // Offers one element and holds it steady until the block takes it. Valid is
    // assigned once per step, so a back-to-back transfer keeps it high.
    task automatic send_element(input logic [ELEM_W-1:0] v, input int gap);
        if (gap > 0)
        begin
            element_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        element_valid <= 1'b1;
        element       <= v;
        do
            @(posedge clk);
        while (element_stall);
        items_sent++;
    endtask

    // Stops offering and waits until every owed product has come out. The first
    // edge lets the input monitor record the final transfer.
    task automatic wait_for_drain();
        element_valid <= 1'b0;
        @(posedge clk);
        while (expected_products.size() != 0) @(posedge clk);
    endtask

    // Input monitor: every accepted transfer goes through the predictor.
    always @(posedge clk)
    begin
        if (rst_n && element_valid && !element_stall)
            load_and_multiply(element);
        if (rst_n && element_valid && element_stall)
            input_held_cycles++;
    end

    // Output monitor: each accepted product is compared with the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_taken++;
            if (expected_products.size() == 0)
            begin
                log_failure($sformatf("unexpected product transfer: product %0d last %0b",
                                      $signed(product), last));
            end
            else
            begin
                front_cell = expected_products.pop_front();
                if (product !== front_cell.product || last !== front_cell.last)
                begin
                    log_failure($sformatf(
                        "product %0d: expected %0d last %0b, got %0d last %0b",
                        results_taken - 1, $signed(front_cell.product),
                        front_cell.last, $signed(product), last));
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no transfer on either side means the
    // block has hung.
    always @(posedge clk)
    begin
        if ((element_valid && !element_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIM)
        begin
            $display("matrix_multiply_3x3: mismatch");
            $finish;
        end
    end

    // Receiver. It stalls in random bursts, with a quiet window of no stalls,
    // and once holds off for a long stretch so that both operand banks fill and
    // the block has to stall its input.
    initial
    begin
        int n;
        result_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!long_hold_done && results_taken >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            n = (results_taken >= 90 && results_taken < 130) ? 0 : pick_gap();
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Sender and sequencing of the run.
    initial
    begin
        int gap;
        rst_n         <= 1'b0;
        element_valid <= 1'b0;
        element       <= '0;
        failures          = 0;
        items_sent        = 0;
        results_taken     = 0;
        input_held_cycles = 0;
        quiet_cycles      = 0;
        long_hold_done    = 1'b0;
        loaded            = 0;

        // First run: the left matrix is all most-negative, each right row is
        // most-negative, most-positive, zero, so the products are typed in. The
        // last seven rows start the next run with mixed extremes and patterns,
        // and the random part finishes it.
        directed_rows = '{
            '{16'h8000, 1'b1, PROD_TOP}, '{16'h8000, 1'b1, PROD_LOW},
            '{16'h8000, 1'b1, PROD_NIL}, '{16'h8000, 1'b1, PROD_TOP},
            '{16'h8000, 1'b1, PROD_LOW}, '{16'h8000, 1'b1, PROD_NIL},
            '{16'h8000, 1'b1, PROD_TOP}, '{16'h8000, 1'b1, PROD_LOW},
            '{16'h8000, 1'b1, PROD_NIL},
            '{16'h8000, 1'b0, PROD_NIL}, '{16'h7FFF, 1'b0, PROD_NIL},
            '{16'h0000, 1'b0, PROD_NIL}, '{16'h8000, 1'b0, PROD_NIL},
            '{16'h7FFF, 1'b0, PROD_NIL}, '{16'h0000, 1'b0, PROD_NIL},
            '{16'h8000, 1'b0, PROD_NIL}, '{16'h7FFF, 1'b0, PROD_NIL},
            '{16'h0000, 1'b0, PROD_NIL},
            '{16'h0001, 1'b0, PROD_NIL}, '{16'hFFFF, 1'b0, PROD_NIL},
            '{16'h7FFF, 1'b0, PROD_NIL}, '{16'h8000, 1'b0, PROD_NIL},
            '{16'h5555, 1'b0, PROD_NIL}, '{16'hAAAA, 1'b0, PROD_NIL},
            '{16'h0000, 1'b0, PROD_NIL}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
        begin
            if (directed_rows[i].typed)
                typed_products.push_back(directed_rows[i].want);
            send_element(directed_rows[i].elem, pick_gap());
        end

        // Random part. Every sequence of elements is a valid load, so all of
        // it exercises the multiply path. A window in the middle offers
        // transfers back to back, and at one matrix boundary the sender pauses
        // until the block has emptied.
        for (int k = 0; k < RANDOM_N; k++)
        begin
            gap = (k >= 120 && k < 160) ? 0 : pick_gap();
            send_element(rand_element(), gap);
            if (items_sent == SETTLE_AT)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Loaded %0d elements as %0d matrix pairs and checked %0d products.",
                 items_sent, items_sent / RUN_ITEMS, results_taken);
        $display("The input was held off for %0d cycles under output back-pressure.",
                 input_held_cycles);
        if (failures == 0)
        begin
            $display("matrix_multiply_3x3: match");
        end
        else
        begin
            $display("%0d failures in total.", failures);
            $display("matrix_multiply_3x3: mismatch");
        end
        $finish;
    end

endmodule
